>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition a implies condition c in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Condition a implies condition c in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/kps_pkg.sv
// ----------------------------------------------------------------------------
// kps_pkg
// Types and constants of the kernel process scheduler.
// ----------------------------------------------------------------------------
package kps_pkg;

  // Service request codes.
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_CREATE_PR = 3'd1,
    OP_SLEEP     = 3'd2,
    OP_CREATE_MX = 3'd3,
    OP_LOCK      = 3'd4,
    OP_UNLOCK    = 3'd5
  } op_e;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_PROC = 2'd1;
  localparam logic [1:0] STAT_NO_MUX  = 2'd2;

  localparam logic [15:0] SLICE_LEN_RST = 16'd300;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE_RD,
    ST_WAKE_CMP,
    ST_TICK_END,
    ST_SUSP_POP,
    ST_DISPATCH
  } state_e;

endpackage

>>> rtl/core/kps_queue.sv
// ----------------------------------------------------------------------------
// kps_queue
// Circular queue of process identifiers with head read and drop-on-full push.
// ----------------------------------------------------------------------------
module kps_queue #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           push_data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [IW-1:0]    head_q;
  logic [CW-1:0]    cnt_q;
  logic [CW:0]      tail_sum;
  logic [CW:0]      tail_wrap;
  logic             pop_ok;
  logic             push_ok;

  // Tail slot is head plus count, folded once into the ring.
  assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(cnt_q);
  assign tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
  assign pop_ok    = pop_i && (cnt_q != '0);
  assign push_ok   = push_i && ((cnt_q != CW'(DEPTH)) || pop_ok);
  assign head_o    = mem_q[head_q];
  assign count_o   = cnt_q;

  // Pointer and count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (pop_ok) begin
        head_q <= (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Storage word write.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[tail_wrap[IW-1:0]] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/kernel_process_scheduler.sv
// ----------------------------------------------------------------------------
// kernel_process_scheduler
// Round-robin kernel scheduler with sleep queue and counting mutexes.
// ----------------------------------------------------------------------------
// Usage: a request word (opcode_i, sleep_ticks_i, mux_id_i, mux_init_i) is
// taken at a clock edge where start is high and busy is low. The block then
// raises busy and works through the request under a small sequencer. When it
// finishes, done_o is high for exactly one cycle with running_pid_o, new_pid_o,
// new_mux_o and status_o; the receiver must take the word in that cycle, it
// cannot stall. busy is low in the done cycle, so a new request may follow.
// Each request passes the execute and dispatch states; an unlock that wakes
// a waiter adds a suspend-queue pop, a tick adds a wake-time read and compare
// per sleeper and a tick-end state. The user must write the slice length
// via cfg_we_i and cfg_wdata_i only while idle; the block does not enforce
// it. Reset empties every queue, frees every identifier, clears time and
// sets slice length 300; no process runs until the first request completes.
// ----------------------------------------------------------------------------
module kernel_process_scheduler #(
  parameter int NUM_PROCS = 16,
  parameter int NUM_MUXES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] sleep_ticks_i,
  input  logic [3:0]  mux_id_i,
  input  logic [7:0]  mux_init_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output logic [3:0]  running_pid_o,
  output logic [3:0]  new_pid_o,
  output logic [3:0]  new_mux_o,
  output logic [1:0]  status_o
);

  `include "assert_macros.svh"

  localparam int PW = $clog2(NUM_PROCS);
  localparam int CW = $clog2(NUM_PROCS + 1);
  localparam int MW = (NUM_MUXES > 1) ? $clog2(NUM_MUXES) : 1;

  kps_pkg::state_e state_q, state_d;

  // Request word held for the duration of the work.
  kps_pkg::op_e op_q;
  logic [15:0]  ticks_q;
  logic [3:0]   mid_q;
  logic [7:0]   minit_q;

  logic [15:0]  slice_len_q;
  logic [31:0]  sys_time_q;
  logic         cur_valid_q;
  logic [PW-1:0] cur_pid_q;
  logic [15:0]  slice_q;
  logic [CW-1:0] pid_alloc_q;
  logic [MW:0]  mux_alloc_q;
  logic [CW-1:0] wk_cnt_q;

  logic         done_q;
  logic [3:0]   run_pid_q;
  logic [3:0]   new_pid_q;
  logic [3:0]   new_mux_q;
  logic [1:0]   status_q;

  // Per-mutex count and suspend-queue pointers.
  logic [7:0]    mcount_q [NUM_MUXES];
  logic [PW-1:0] shead_q  [NUM_MUXES];
  logic [CW-1:0] scnt_q   [NUM_MUXES];

  // Memories: wake times by process and suspend queues by mutex and slot.
  logic [31:0]   wake_mem [NUM_PROCS];
  logic [31:0]   wake_rdata_q;
  logic [PW-1:0] susp_mem [(2**MW)*(2**PW)];
  logic [PW-1:0] susp_rdata_q;

  logic          rq_push, rq_pop, sq_push, sq_pop;
  logic [PW-1:0] rq_push_data, sq_push_data, rq_head, sq_head;
  logic [CW-1:0] rq_cnt, sq_cnt;

  logic          accept;
  logic          user;
  logic          mid_ok;
  logic [MW-1:0] mid_idx;
  logic [MW-1:0] mux_new_idx;
  logic [PW-1:0] pid_new;
  logic          pid_empty;
  logic          mux_empty;
  logic [15:0]   slice_inc;
  logic          preempt;
  logic          due;
  logic          need_disp;
  logic [CW:0]   stail_sum;
  logic [CW:0]   stail_wrap;
  logic          lock_push;

  assign accept      = start && !busy;
  assign busy        = (state_q != kps_pkg::ST_IDLE);
  assign user        = cur_valid_q && (cur_pid_q != '0);
  assign mid_ok      = ({28'd0, mid_q} < 32'(NUM_MUXES));
  assign mid_idx     = MW'(mid_q);
  assign mux_new_idx = mux_alloc_q[MW-1:0];
  assign pid_new     = pid_alloc_q[PW-1:0];
  assign pid_empty   = (pid_alloc_q == CW'(NUM_PROCS));
  assign mux_empty   = (mux_alloc_q == (MW+1)'(NUM_MUXES));
  assign slice_inc   = slice_q + 16'd1;
  assign preempt     = user && (slice_inc >= slice_len_q);
  assign due         = (wake_rdata_q <= sys_time_q);
  assign need_disp   = !cur_valid_q || (cur_pid_q == '0);

  // Tail slot of the addressed suspend queue.
  assign stail_sum  = (CW+1)'(shead_q[mid_idx]) + (CW+1)'(scnt_q[mid_idx]);
  assign stail_wrap = (stail_sum >= (CW+1)'(NUM_PROCS)) ?
                      stail_sum - (CW+1)'(NUM_PROCS) : stail_sum;
  assign lock_push  = (state_q == kps_pkg::ST_EXEC) && (op_q == kps_pkg::OP_LOCK) &&
                      user && mid_ok && (mcount_q[mid_idx] == 8'd0) &&
                      (scnt_q[mid_idx] != CW'(NUM_PROCS));

  // Ready and sleep queues.
  kps_queue #(.DEPTH(NUM_PROCS), .WIDTH(PW)) u_ready_q (
    .clk_i, .rst_ni, .push_i(rq_push), .push_data_i(rq_push_data), .pop_i(rq_pop),
    .head_o(rq_head), .count_o(rq_cnt)
  );

  kps_queue #(.DEPTH(NUM_PROCS), .WIDTH(PW)) u_sleep_q (
    .clk_i, .rst_ni, .push_i(sq_push), .push_data_i(sq_push_data), .pop_i(sq_pop),
    .head_o(sq_head), .count_o(sq_cnt)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kps_pkg::ST_IDLE: begin
        if (accept) state_d = kps_pkg::ST_EXEC;
      end
      kps_pkg::ST_EXEC: begin
        state_d = kps_pkg::ST_DISPATCH;
        if (op_q == kps_pkg::OP_TICK) begin
          state_d = (sq_cnt != '0) ? kps_pkg::ST_WAKE_RD : kps_pkg::ST_TICK_END;
        end else if ((op_q == kps_pkg::OP_UNLOCK) && user && mid_ok &&
                     (scnt_q[mid_idx] != '0)) begin
          state_d = kps_pkg::ST_SUSP_POP;
        end
      end
      kps_pkg::ST_WAKE_RD:  state_d = kps_pkg::ST_WAKE_CMP;
      kps_pkg::ST_WAKE_CMP: begin
        state_d = (wk_cnt_q == CW'(1)) ? kps_pkg::ST_TICK_END : kps_pkg::ST_WAKE_RD;
      end
      kps_pkg::ST_TICK_END: state_d = kps_pkg::ST_DISPATCH;
      kps_pkg::ST_SUSP_POP: state_d = kps_pkg::ST_DISPATCH;
      kps_pkg::ST_DISPATCH: state_d = kps_pkg::ST_IDLE;
      default:              state_d = kps_pkg::ST_IDLE;
    endcase
  end

  // Queue controls per state.
  always_comb begin
    rq_push      = 1'b0;
    rq_push_data = cur_pid_q;
    rq_pop       = 1'b0;
    sq_push      = 1'b0;
    sq_push_data = cur_pid_q;
    sq_pop       = 1'b0;
    unique case (state_q)
      kps_pkg::ST_EXEC: begin
        if (op_q == kps_pkg::OP_CREATE_PR) begin
          rq_push      = !pid_empty && (pid_new != '0);
          rq_push_data = pid_new;
        end else if (op_q == kps_pkg::OP_SLEEP) begin
          sq_push = user;
        end
      end
      kps_pkg::ST_WAKE_CMP: begin
        sq_pop       = 1'b1;
        rq_push      = due;
        rq_push_data = sq_head;
        sq_push      = !due;
        sq_push_data = sq_head;
      end
      kps_pkg::ST_TICK_END: rq_push = preempt;
      kps_pkg::ST_SUSP_POP: begin
        rq_push      = 1'b1;
        rq_push_data = susp_rdata_q;
      end
      kps_pkg::ST_DISPATCH: rq_pop = need_disp && (rq_cnt != '0);
      default: begin
      end
    endcase
  end

  // Sequencer and scheduler registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kps_pkg::ST_IDLE;
      slice_len_q  <= kps_pkg::SLICE_LEN_RST;
      sys_time_q   <= '0;
      cur_valid_q  <= 1'b0;
      cur_pid_q    <= '0;
      slice_q      <= '0;
      pid_alloc_q  <= '0;
      mux_alloc_q  <= '0;
      wk_cnt_q     <= '0;
      done_q       <= 1'b0;
      for (int i = 0; i < NUM_MUXES; i++) begin
        mcount_q[i] <= '0;
        shead_q[i]  <= '0;
        scnt_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == kps_pkg::ST_DISPATCH);
      if (cfg_we_i) slice_len_q <= cfg_wdata_i;
      unique case (state_q)
        kps_pkg::ST_EXEC: begin
          unique case (op_q)
            kps_pkg::OP_TICK: begin
              sys_time_q <= sys_time_q + 32'd1;
              wk_cnt_q   <= sq_cnt;
            end
            kps_pkg::OP_CREATE_PR: begin
              if (!pid_empty) pid_alloc_q <= pid_alloc_q + 1'b1;
            end
            kps_pkg::OP_SLEEP: begin
              if (user) cur_valid_q <= 1'b0;
            end
            kps_pkg::OP_CREATE_MX: begin
              if (!mux_empty) begin
                mux_alloc_q           <= mux_alloc_q + 1'b1;
                mcount_q[mux_new_idx] <= minit_q;
                shead_q[mux_new_idx]  <= '0;
                scnt_q[mux_new_idx]   <= '0;
              end
            end
            kps_pkg::OP_LOCK: begin
              if (user && mid_ok) begin
                if (mcount_q[mid_idx] != 8'd0) begin
                  mcount_q[mid_idx] <= mcount_q[mid_idx] - 8'd1;
                end else if (lock_push) begin
                  scnt_q[mid_idx] <= scnt_q[mid_idx] + 1'b1;
                  cur_valid_q     <= 1'b0;
                end
              end
            end
            kps_pkg::OP_UNLOCK: begin
              if (user && mid_ok && (scnt_q[mid_idx] == '0) &&
                  (mcount_q[mid_idx] != 8'hFF)) begin
                mcount_q[mid_idx] <= mcount_q[mid_idx] + 8'd1;
              end
            end
            default: begin
            end
          endcase
        end
        kps_pkg::ST_WAKE_CMP: wk_cnt_q <= wk_cnt_q - 1'b1;
        kps_pkg::ST_TICK_END: begin
          if (user) begin
            slice_q <= slice_inc;
            if (preempt) cur_valid_q <= 1'b0;
          end
        end
        kps_pkg::ST_SUSP_POP: begin
          shead_q[mid_idx] <= (shead_q[mid_idx] == PW'(NUM_PROCS - 1)) ? '0 :
                              shead_q[mid_idx] + 1'b1;
          scnt_q[mid_idx]  <= scnt_q[mid_idx] - 1'b1;
        end
        kps_pkg::ST_DISPATCH: begin
          if (need_disp) begin
            cur_valid_q <= 1'b1;
            if (rq_cnt != '0) begin
              cur_pid_q <= rq_head;
              slice_q   <= '0;
            end else begin
              cur_pid_q <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture and result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= kps_pkg::op_e'(opcode_i);
      ticks_q   <= sleep_ticks_i;
      mid_q     <= mux_id_i;
      minit_q   <= mux_init_i;
      new_pid_q <= '0;
      new_mux_q <= '0;
      status_q  <= kps_pkg::STAT_OK;
    end else if (state_q == kps_pkg::ST_EXEC) begin
      if (op_q == kps_pkg::OP_CREATE_PR) begin
        if (pid_empty) status_q <= kps_pkg::STAT_NO_PROC;
        else           new_pid_q <= 4'(pid_new);
      end else if (op_q == kps_pkg::OP_CREATE_MX) begin
        if (mux_empty) status_q <= kps_pkg::STAT_NO_MUX;
        else           new_mux_q <= 4'(mux_new_idx);
      end
    end
    if (state_q == kps_pkg::ST_DISPATCH) begin
      if (!need_disp)          run_pid_q <= 4'(cur_pid_q);
      else if (rq_cnt != '0)   run_pid_q <= 4'(rq_head);
      else                     run_pid_q <= 4'd0;
    end
  end

  // Wake-time memory: written on sleep, read at the sleep queue head.
  always_ff @(posedge clk_i) begin
    if ((state_q == kps_pkg::ST_EXEC) && (op_q == kps_pkg::OP_SLEEP) && user) begin
      wake_mem[cur_pid_q] <= sys_time_q + {16'd0, ticks_q};
    end
    wake_rdata_q <= wake_mem[sq_head];
  end

  // Suspend-queue memory: written on a blocking lock, read at the queue head.
  always_ff @(posedge clk_i) begin
    if (lock_push) begin
      susp_mem[{mid_idx, stail_wrap[PW-1:0]}] <= cur_pid_q;
    end
    susp_rdata_q <= susp_mem[{mid_idx, shead_q[mid_idx]}];
  end

  assign done_o        = done_q;
  assign running_pid_o = run_pid_q;
  assign new_pid_o     = new_pid_q;
  assign new_mux_o     = new_mux_q;
  assign status_o      = status_q;

  // Checks on the sequencer and queues.
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy && !done_o)
  `ASSERT_IMPL(a_ready_bound, clk_i, rst_ni, 1'b1, rq_cnt <= CW'(NUM_PROCS))

endmodule
